// ----- rtl/core/rci_pkg.sv -----
// Shared types and constants for the ray / infinite cylinder intersection core.
// No dependencies; imported by every file under rtl/core.
`timescale 1ns / 1ps
package rci_pkg;
  localparam int FRAC_BITS  = 16;
  localparam int COORD_W    = 32;
  localparam int TAG_W      = 8;
  localparam int EPS_W      = 16;
  localparam int SQRT_STEPS = 64;
  localparam int DIV_STEPS  = 32;
  localparam int DIV_DW     = 65 + FRAC_BITS;   // width of |num| << FRAC_BITS
  localparam int CMP_W      = 97;                // overflow compare against a << 32
  localparam int REM_W      = 65;
  localparam int SQ_REM_W   = 67;
  localparam int NUM_LANES  = 2;                 // 0: near root, 1: far root
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;
  localparam logic [63:0] ONE_Q = 64'd1 << (2 * FRAC_BITS);

  typedef struct packed {
    logic              hit;
    logic [63:0]       a;
    logic signed [64:0] btc;
    logic [TAG_W-1:0]  tag;
  } rci_side_t;

  typedef struct packed {
    rci_side_t    side;
    logic [127:0] d;
  } rci_front_t;

  typedef struct packed {
    rci_side_t   side;
    logic [63:0] s;
  } rci_root_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] t_near;
    logic signed [COORD_W-1:0] t_far;
    logic [TAG_W-1:0]          tag;
  } rci_res_t;
endpackage

// ----- rtl/core/rci_in_if.sv -----
// Input ray channel: valid/ready plus ray x/z components and object tag.
// Depends on rci_pkg.
`timescale 1ns / 1ps
interface rci_in_if;
  import rci_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] orig_x;
  logic signed [COORD_W-1:0] orig_z;
  logic signed [COORD_W-1:0] dir_x;
  logic signed [COORD_W-1:0] dir_z;
  logic [TAG_W-1:0]          object_tag;
  modport source (output valid, orig_x, orig_z, dir_x, dir_z, object_tag, input ready);
  modport sink   (input valid, orig_x, orig_z, dir_x, dir_z, object_tag, output ready);
endinterface

// ----- rtl/core/rci_out_if.sv -----
// Result channel: valid/ready plus hit flag, both roots and object tag.
// Depends on rci_pkg.
`timescale 1ns / 1ps
interface rci_out_if;
  import rci_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic signed [COORD_W-1:0] t_near;
  logic signed [COORD_W-1:0] t_far;
  logic [TAG_W-1:0]          object_tag_out;
  modport source (output valid, hit, t_near, t_far, object_tag_out, input ready);
  modport sink   (input valid, hit, t_near, t_far, object_tag_out, output ready);
endinterface

// ----- rtl/core/rci_cfg_if.sv -----
// Configuration write channel carrying the parallel epsilon register.
// Depends on rci_pkg.
`timescale 1ns / 1ps
interface rci_cfg_if;
  import rci_pkg::*;
  logic             valid;
  logic             ready;
  logic [EPS_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/core/rci_front.sv -----
// Front end: quadratic coefficients, parallel test and discriminant (6 stages).
// Depends on rci_pkg.
`timescale 1ns / 1ps
module rci_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [rci_pkg::COORD_W-1:0] orig_x,
  input  logic signed [rci_pkg::COORD_W-1:0] orig_z,
  input  logic signed [rci_pkg::COORD_W-1:0] dir_x,
  input  logic signed [rci_pkg::COORD_W-1:0] dir_z,
  input  logic [rci_pkg::TAG_W-1:0]          tag,
  input  logic [rci_pkg::EPS_W-1:0]          eps,
  output logic                               out_valid,
  output rci_pkg::rci_front_t                out_data
);
  import rci_pkg::*;

  logic [5:0] v_r;

  // stage 1: six squares/cross products
  logic signed [63:0] dxx_r, dzz_r, oxdx_r, ozdz_r, oxx_r, ozz_r;
  logic [TAG_W-1:0]   tag1_r;
  // stage 2: coefficient sums
  logic [63:0]        a2_r, q2_r;
  logic signed [64:0] btc2_r;
  logic [TAG_W-1:0]   tag2_r;
  // stage 3: magnitudes, parallel test
  logic [63:0]        a3_r, bmag3_r, cmag3_r;
  logic signed [64:0] btc3_r;
  logic               qge3_r, par3_r;
  logic [TAG_W-1:0]   tag3_r;
  // stage 4: 32x32 partial products
  logic [63:0]        bb00_r, bb01_r, bb11_r, ac00_r, ac01_r, ac10_r, ac11_r;
  logic [63:0]        a4_r;
  logic signed [64:0] btc4_r;
  logic               qge4_r, par4_r;
  logic [TAG_W-1:0]   tag4_r;
  // stage 5: full products
  logic [127:0]       bsq5_r, ac5_r;
  logic [63:0]        a5_r;
  logic signed [64:0] btc5_r;
  logic               qge5_r, par5_r;
  logic [TAG_W-1:0]   tag5_r;
  // stage 6
  rci_front_t         out_r;

  logic [63:0] eps_q;
  logic [64:0] acmid;
  assign eps_q = {{(64 - EPS_W - FRAC_BITS){1'b0}}, eps, {FRAC_BITS{1'b0}}};
  assign acmid = {1'b0, ac01_r} + {1'b0, ac10_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dxx_r  <= dir_x * dir_x;
      dzz_r  <= dir_z * dir_z;
      oxdx_r <= orig_x * dir_x;
      ozdz_r <= orig_z * dir_z;
      oxx_r  <= orig_x * orig_x;
      ozz_r  <= orig_z * orig_z;
      tag1_r <= tag;

      a2_r   <= dxx_r + dzz_r;
      q2_r   <= oxx_r + ozz_r;
      btc2_r <= $signed({oxdx_r[63], oxdx_r}) + $signed({ozdz_r[63], ozdz_r});
      tag2_r <= tag1_r;

      a3_r    <= a2_r;
      btc3_r  <= btc2_r;
      bmag3_r <= 64'(btc2_r[64] ? -btc2_r : btc2_r);
      qge3_r  <= q2_r >= ONE_Q;
      cmag3_r <= (q2_r >= ONE_Q) ? (q2_r - ONE_Q) : (ONE_Q - q2_r);
      par3_r  <= (a2_r == 64'd0) || (a2_r < eps_q);
      tag3_r  <= tag2_r;

      bb00_r <= bmag3_r[31:0]  * bmag3_r[31:0];
      bb01_r <= bmag3_r[31:0]  * bmag3_r[63:32];
      bb11_r <= bmag3_r[63:32] * bmag3_r[63:32];
      ac00_r <= a3_r[31:0]  * cmag3_r[31:0];
      ac01_r <= a3_r[31:0]  * cmag3_r[63:32];
      ac10_r <= a3_r[63:32] * cmag3_r[31:0];
      ac11_r <= a3_r[63:32] * cmag3_r[63:32];
      a4_r   <= a3_r;
      btc4_r <= btc3_r;
      qge4_r <= qge3_r;
      par4_r <= par3_r;
      tag4_r <= tag3_r;

      // cross term appears twice: shift by 33
      bsq5_r <= {bb11_r, 64'd0} + {31'd0, bb01_r, 33'd0} + {64'd0, bb00_r};
      ac5_r  <= {ac11_r, 64'd0} + {31'd0, acmid, 32'd0} + {64'd0, ac00_r};
      a5_r   <= a4_r;
      btc5_r <= btc4_r;
      qge5_r <= qge4_r;
      par5_r <= par4_r;
      tag5_r <= tag4_r;

      out_r.side.hit <= !par5_r && !(qge5_r && (bsq5_r < ac5_r));
      out_r.side.a   <= a5_r;
      out_r.side.btc <= btc5_r;
      out_r.side.tag <= tag5_r;
      out_r.d        <= qge5_r ? (bsq5_r - ac5_r) : (bsq5_r + ac5_r);
    end
  end

  assign out_valid = v_r[5];
  assign out_data  = out_r;
endmodule

// ----- rtl/core/rci_sqrt.sv -----
// Pipelined integer square root, one result bit per stage (64 stages).
// Depends on rci_pkg.
`timescale 1ns / 1ps
module rci_sqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  rci_pkg::rci_front_t in_data,
  output logic                out_valid,
  output rci_pkg::rci_root_t  out_data
);
  import rci_pkg::*;

  logic                v_r    [SQRT_STEPS];
  logic [127:0]        x_r    [SQRT_STEPS];
  logic [SQ_REM_W-1:0] rem_r  [SQRT_STEPS];
  logic [63:0]         root_r [SQRT_STEPS];
  rci_side_t           side_r [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic                vi;
    logic [127:0]        xi;
    logic [SQ_REM_W-1:0] remi, rem_t, trial;
    logic [63:0]         rooti;
    rci_side_t           sidei;
    logic                ge;

    if (k == 0) begin : g_first
      assign vi    = in_valid;
      assign xi    = in_data.d;
      assign remi  = '0;
      assign rooti = '0;
      assign sidei = in_data.side;
    end else begin : g_next
      assign vi    = v_r[k-1];
      assign xi    = x_r[k-1];
      assign remi  = rem_r[k-1];
      assign rooti = root_r[k-1];
      assign sidei = side_r[k-1];
    end

    assign rem_t = {remi[SQ_REM_W-3:0], xi[127:126]};
    assign trial = {1'b0, rooti, 2'b01};
    assign ge    = rem_t >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]    <= {xi[125:0], 2'b00};
        rem_r[k]  <= ge ? (rem_t - trial) : rem_t;
        root_r[k] <= {rooti[62:0], ge};
        side_r[k] <= sidei;
      end
    end
  end

  assign out_valid     = v_r[SQRT_STEPS-1];
  assign out_data.side = side_r[SQRT_STEPS-1];
  assign out_data.s    = root_r[SQRT_STEPS-1];
endmodule

// ----- rtl/core/rci_div.sv -----
// Root numerators, two-lane restoring divide by a, and saturation (36 stages).
// Depends on rci_pkg.
`timescale 1ns / 1ps
module rci_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  rci_pkg::rci_root_t in_data,
  output logic               out_valid,
  output rci_pkg::rci_res_t  out_data
);
  import rci_pkg::*;

  // numerator stage
  logic               v1_r;
  logic signed [65:0] num1_r [NUM_LANES];
  rci_side_t          side1_r;
  // magnitude stage
  logic               v2_r;
  logic [64:0]        mag2_r [NUM_LANES];
  logic               neg2_r [NUM_LANES];
  rci_side_t          side2_r;
  // divide setup
  logic               v3_r;
  logic [REM_W-1:0]   rem3_r [NUM_LANES];
  logic [31:0]        lo3_r  [NUM_LANES];
  logic               neg3_r [NUM_LANES];
  logic               big3_r [NUM_LANES];
  rci_side_t          side3_r;
  // divide steps
  logic               dv_r   [DIV_STEPS];
  logic [REM_W-1:0]   drem_r [DIV_STEPS][NUM_LANES];
  logic [31:0]        dlo_r  [DIV_STEPS][NUM_LANES];
  logic [31:0]        dq_r   [DIV_STEPS][NUM_LANES];
  logic               dneg_r [DIV_STEPS][NUM_LANES];
  logic               dbig_r [DIV_STEPS][NUM_LANES];
  rci_side_t          dside_r [DIV_STEPS];
  // saturation
  logic               vo_r;
  rci_res_t           res_r;

  logic signed [64:0] negb;
  assign negb = -in_data.side.btc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    logic [DIV_DW-1:0] dvd;
    assign dvd = {mag2_r[l], {FRAC_BITS{1'b0}}};

    always_ff @(posedge clk) begin
      if (en) begin
        if (l == 0) begin
          num1_r[l] <= $signed({negb[64], negb}) - $signed({2'b00, in_data.s});
        end else begin
          num1_r[l] <= $signed({negb[64], negb}) + $signed({2'b00, in_data.s});
        end
        neg2_r[l] <= num1_r[l][65];
        mag2_r[l] <= 65'(num1_r[l][65] ? -num1_r[l] : num1_r[l]);
        neg3_r[l] <= neg2_r[l];
        big3_r[l] <= CMP_W'(dvd) >= {1'b0, side2_r.a, 32'd0};
        rem3_r[l] <= REM_W'(dvd[DIV_DW-1:32]);
        lo3_r[l]  <= dvd[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r <= in_data.side;
      side2_r <= side1_r;
      side3_r <= side2_r;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic      vi;
    rci_side_t sidei;

    if (k == 0) begin : g_first
      assign vi    = v3_r;
      assign sidei = side3_r;
    end else begin : g_next
      assign vi    = dv_r[k-1];
      assign sidei = dside_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k] <= 1'b0;
      end else if (en) begin
        dv_r[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dside_r[k] <= sidei;
      end
    end

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      logic [REM_W-1:0] remi, rem_t;
      logic [31:0]      loi, qi;
      logic             negi, bigi, ge;

      if (k == 0) begin : g_first
        assign remi = rem3_r[l];
        assign loi  = lo3_r[l];
        assign qi   = '0;
        assign negi = neg3_r[l];
        assign bigi = big3_r[l];
      end else begin : g_next
        assign remi = drem_r[k-1][l];
        assign loi  = dlo_r[k-1][l];
        assign qi   = dq_r[k-1][l];
        assign negi = dneg_r[k-1][l];
        assign bigi = dbig_r[k-1][l];
      end

      // remainder stays below a unless the quotient already overflowed
      assign rem_t = {remi[REM_W-2:0], loi[31]};
      assign ge    = rem_t >= {1'b0, sidei.a};

      always_ff @(posedge clk) begin
        if (en) begin
          drem_r[k][l] <= ge ? (rem_t - {1'b0, sidei.a}) : rem_t;
          dlo_r[k][l]  <= {loi[30:0], 1'b0};
          dq_r[k][l]   <= {qi[30:0], ge};
          dneg_r[k][l] <= negi;
          dbig_r[k][l] <= bigi;
        end
      end
    end
  end

  // saturate to the signed 32-bit range
  function automatic logic [31:0] sat_root(input logic [31:0] q, input logic neg,
                                           input logic big);
    logic [31:0] r;
    if (neg) begin
      r = (big || (q > 32'h8000_0000)) ? 32'h8000_0000 : (32'd0 - q);
    end else begin
      r = (big || q[31]) ? 32'h7FFF_FFFF : q;
    end
    return r;
  endfunction

  logic [31:0] sat_near, sat_far;
  rci_side_t   last_side;
  assign last_side = dside_r[DIV_STEPS-1];
  assign sat_near  = sat_root(dq_r[DIV_STEPS-1][0], dneg_r[DIV_STEPS-1][0],
                              dbig_r[DIV_STEPS-1][0]);
  assign sat_far   = sat_root(dq_r[DIV_STEPS-1][1], dneg_r[DIV_STEPS-1][1],
                              dbig_r[DIV_STEPS-1][1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= dv_r[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r.hit    <= last_side.hit;
      res_r.t_near <= last_side.hit ? $signed(sat_near) : '0;
      res_r.t_far  <= last_side.hit ? $signed(sat_far) : '0;
      res_r.tag    <= last_side.tag;
    end
  end

  assign out_valid = vo_r;
  assign out_data  = res_r;
endmodule

// ----- rtl/core/ray_cylinder_intersect.sv -----
// Ray versus infinite unit cylinder (axis y), signed Q16.16, fully pipelined.
// Pipeline: front end, square root, divide/saturate, then one output register.
// Throughput: one beat per cycle while the output skid slot is not full.
// The 64-step square root and 32-step divide pipelines set the latency.
// Reset (rst_n low, synchronous) empties the pipeline and sets epsilon to 1.
`timescale 1ns / 1ps
module ray_cylinder_intersect (
  input logic        clk,
  input logic        rst_n,
  rci_in_if.sink     in_ch,
  rci_out_if.source  out_ch,
  rci_cfg_if.sink    cfg_ch
);
  import rci_pkg::*;

  // config register: the user must write it only while the block is idle; the block itself does not enforce this
  logic [EPS_W-1:0] eps_r;

  // whole pipeline moves together; frozen only when the skid slot is full
  logic       en;
  logic       front_v, sqrt_v, div_v;
  rci_front_t front_d;
  rci_root_t  sqrt_d;
  rci_res_t   div_d;

  // output register plus one skid slot
  logic     out_v_r, skid_v_r;
  rci_res_t out_r, skid_r;
  logic     push, pop;

  assign en           = !skid_v_r;
  assign in_ch.ready  = en;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (cfg_ch.valid) begin
      eps_r <= cfg_ch.data;
    end
  end

  // coefficients and discriminant
  rci_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .orig_x    (in_ch.orig_x),
    .orig_z    (in_ch.orig_z),
    .dir_x     (in_ch.dir_x),
    .dir_z     (in_ch.dir_z),
    .tag       (in_ch.object_tag),
    .eps       (eps_r),
    .out_valid (front_v),
    .out_data  (front_d)
  );

  // floor(sqrt(D))
  rci_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (front_v),
    .in_data   (front_d),
    .out_valid (sqrt_v),
    .out_data  (sqrt_d)
  );

  // (-B -/+ S) << F / A for both roots, then saturation
  rci_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sqrt_v),
    .in_data   (sqrt_d),
    .out_valid (div_v),
    .out_data  (div_d)
  );

  assign push = en && div_v;
  assign pop  = out_v_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        skid_v_r <= 1'b0;
      end
    end else if (!out_v_r || pop) begin
      out_v_r <= push;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (!out_v_r || pop) begin
      out_r <= div_d;
    end else begin
      skid_r <= div_d;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.hit            = out_r.hit;
  assign out_ch.t_near         = out_r.t_near;
  assign out_ch.t_far          = out_r.t_far;
  assign out_ch.object_tag_out = out_r.tag;
endmodule
